/* sv/polynomial_term_store_eval_derive_defines.svh */
// ----------------------------------------------------------------------------
// polynomial term store assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_TERM_STORE_EVAL_DERIVE_DEFINES_SVH
`define POLYNOMIAL_TERM_STORE_EVAL_DERIVE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTSED_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same cycle implication");
`define PTSED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next cycle implication");
`else
`define PTSED_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PTSED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/ptsed_pkg.sv */
// ----------------------------------------------------------------------------
// ptsed_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptsed_pkg;

   localparam int MAX_EXP     = 15;
   localparam int FRAC_BITS   = 16;
   localparam int TABLE_DEPTH = MAX_EXP + 1;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int DATA_W = 32;
   localparam int EXP_W  = 6;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int KIND_W = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_EVAL  = 2'd1;
   localparam logic [OP_W-1:0] OP_DERIV = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // result status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_SAT   = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

   // which result the datapath loads into the output register
   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EVAL  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DERIV = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   typedef struct packed {
      logic              load;      // capture item, restart index and accumulator
      logic              sel_term;  // table read at the term exponent
      logic              mul_en;    // horner multiply step
      logic              acc_en;    // horner accumulate step
      logic              idx_dec;
      logic              emit;
      logic [KIND_W-1:0] emit_kind;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic idx_zero;
      logic deriv_any;
      logic cur_present;
      logic cur_last;
   } stat_type;

endpackage

`default_nettype wire

/* sv/ptsed_ctrl.sv */
// ----------------------------------------------------------------------------
// ptsed_ctrl
// operation sequencer: add, horner evaluation, derivative scan, clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptsed_ctrl
   import ptsed_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_operation,
   input  wire stat_type        st,
   output cmd_type              cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADD  = 3'd1;
   localparam logic [2:0] S_CLR  = 3'd2;
   localparam logic [2:0] S_EMUL = 3'd3;
   localparam logic [2:0] S_EACC = 3'd4;
   localparam logic [2:0] S_EOUT = 3'd5;
   localparam logic [2:0] S_DER  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               unique case (req_operation)
                  OP_ADD:   state_in = S_ADD;
                  OP_EVAL:  state_in = S_EMUL;
                  OP_DERIV: state_in = S_DER;
                  OP_CLEAR: state_in = S_CLR;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            cmd.sel_term  = 1'b1;
            cmd.emit_kind = KIND_ADD;
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            cmd.emit_kind = KIND_CLEAR;
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_EACC;
         end
         S_EACC: begin
            cmd.acc_en = 1'b1;
            if (st.idx_zero) begin
               state_in = S_EOUT;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = S_EMUL;
            end
         end
         S_EOUT: begin
            cmd.emit_kind = KIND_EVAL;
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DER: begin
            if (!st.deriv_any) begin
               cmd.emit_kind = KIND_EMPTY;
               if (st.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (!st.cur_present) begin
               // absent entry, step past it
               cmd.idx_dec = 1'b1;
            end else begin
               cmd.emit_kind = KIND_DERIV;
               if (st.out_free) begin
                  cmd.emit = 1'b1;
                  if (st.cur_last) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_dec = 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/ptsed_dp.sv */
// ----------------------------------------------------------------------------
// ptsed_dp
// coefficient table, horner multiply-accumulate, derivative scaler, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptsed_dp
   import ptsed_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output stat_type                      st,
   input  wire logic signed [DATA_W-1:0] req_term_coefficient,
   input  wire logic        [EXP_W-1:0]  req_term_exponent,
   input  wire logic signed [DATA_W-1:0] req_point_x,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_result_value,
   output logic        [EXP_W-1:0]       rsp_result_exponent,
   output logic        [ST_W-1:0]        rsp_status,
   output logic                          rsp_last
);

   localparam int PROD_W = 2 * DATA_W;
   localparam int DER_W  = DATA_W + IDX_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      (FRAC_BITS > 0) ? (PROD_W'(1) <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // coefficient store; an entry without its present bit reads as zero
   logic signed [DATA_W-1:0] coef_mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   present_ff;

   logic signed [DATA_W-1:0] term_ff;
   logic [EXP_W-1:0]         texp_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [DATA_W-1:0] acc_ff;
   logic signed [DATA_W-1:0] acc_in;
   logic                     sat_ff;
   logic                     sat_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic signed [DATA_W-1:0] out_value_in;
   logic [EXP_W-1:0]         out_exp_ff;
   logic [EXP_W-1:0]         out_exp_in;
   logic [ST_W-1:0]          out_status_ff;
   logic [ST_W-1:0]          out_status_in;
   logic                     out_last_ff;
   logic                     out_last_in;

   logic [IDX_W-1:0]         exp_idx;
   logic                     exp_range;
   logic [IDX_W-1:0]         rd_idx;
   logic signed [DATA_W-1:0] coef_rd;

   logic signed [DATA_W:0]   add_sum;
   logic signed [DATA_W-1:0] add_value;
   logic                     add_sat;

   logic signed [PROD_W-1:0] scaled;
   logic                     scale_sat;
   logic signed [DATA_W-1:0] scaled_q;
   logic signed [DATA_W:0]   horner_sum;
   logic                     horner_sat;

   logic signed [DER_W-1:0]  der_prod;
   logic                     der_sat;
   logic signed [DATA_W-1:0] der_value;
   logic [IDX_W-1:0]         idx_m1;
   logic                     lower_any;

   assign exp_idx   = texp_ff[IDX_W-1:0];
   assign exp_range = (texp_ff > EXP_W'(MAX_EXP));
   assign rd_idx    = cmd.sel_term ? exp_idx : idx_ff;
   assign coef_rd   = present_ff[rd_idx] ? coef_mem_ff[rd_idx] : '0;

   // merge of a term into its entry
   assign add_sum   = {coef_rd[DATA_W-1], coef_rd} + {term_ff[DATA_W-1], term_ff};
   assign add_sat   = add_sum[DATA_W] ^ add_sum[DATA_W-1];
   assign add_value = add_sat ? (add_sum[DATA_W] ? Q_MIN : Q_MAX) : add_sum[DATA_W-1:0];

   // horner step, multiply half
   assign prod_in = acc_ff * x_ff;

   // horner step, round to nearest (ties up), saturate, add coefficient, saturate
   assign scaled     = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
   assign scale_sat  = !((&scaled[PROD_W-1:DATA_W-1]) || !(|scaled[PROD_W-1:DATA_W-1]));
   assign scaled_q   = scale_sat ? (scaled[PROD_W-1] ? Q_MIN : Q_MAX)
                                 : scaled[DATA_W-1:0];
   assign horner_sum = {scaled_q[DATA_W-1], scaled_q} + {coef_rd[DATA_W-1], coef_rd};
   assign horner_sat = horner_sum[DATA_W] ^ horner_sum[DATA_W-1];
   assign acc_in     = horner_sat ? (horner_sum[DATA_W] ? Q_MIN : Q_MAX)
                                  : horner_sum[DATA_W-1:0];
   assign sat_in     = sat_ff | scale_sat | horner_sat;

   // derivative coefficient c*e
   assign der_prod  = coef_rd * $signed({1'b0, idx_ff});
   assign der_sat   = !((&der_prod[DER_W-1:DATA_W-1]) || !(|der_prod[DER_W-1:DATA_W-1]));
   assign der_value = der_sat ? (der_prod[DER_W-1] ? Q_MIN : Q_MAX) : der_prod[DATA_W-1:0];
   assign idx_m1    = idx_ff - IDX_W'(1);

   // any present term of exponent one or more below the current index
   always_comb begin
      lower_any = 1'b0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         if (present_ff[i] && (IDX_W'(i) < idx_ff)) begin
            lower_any = 1'b1;
         end
      end
   end

   assign st.out_free    = !out_valid_ff || rsp_ready;
   assign st.idx_zero    = (idx_ff == '0);
   assign st.deriv_any   = |present_ff[TABLE_DEPTH-1:1];
   assign st.cur_present = present_ff[idx_ff];
   assign st.cur_last    = !lower_any;

   always_comb begin
      out_value_in  = '0;
      out_exp_in    = '0;
      out_status_in = ST_OK;
      out_last_in   = 1'b1;
      unique case (cmd.emit_kind)
         KIND_ADD: begin
            if (exp_range) begin
               out_status_in = ST_RANGE;
            end else begin
               out_value_in  = add_value;
               out_exp_in    = texp_ff;
               out_status_in = add_sat ? ST_SAT : ST_OK;
            end
         end
         KIND_EVAL: begin
            if (|present_ff) begin
               out_value_in  = acc_ff;
               out_status_in = sat_ff ? ST_SAT : ST_OK;
            end else begin
               out_status_in = ST_EMPTY;
            end
         end
         KIND_DERIV: begin
            out_value_in  = der_value;
            out_exp_in    = EXP_W'(idx_m1);
            out_status_in = der_sat ? ST_SAT : ST_OK;
            out_last_in   = !lower_any;
         end
         KIND_EMPTY: out_status_in = ST_EMPTY;
         KIND_CLEAR: out_status_in = ST_OK;
         default:    out_status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         term_ff <= req_term_coefficient;
         texp_ff <= req_term_exponent;
         x_ff    <= req_point_x;
         idx_ff  <= IDX_W'(MAX_EXP);
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.idx_dec) begin
            idx_ff <= idx_m1;
         end
         if (cmd.acc_en) begin
            acc_ff <= acc_in;
            sat_ff <= sat_in;
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.emit && (cmd.emit_kind == KIND_ADD) && !exp_range) begin
         coef_mem_ff[exp_idx] <= add_value;
      end
      if (cmd.emit) begin
         out_value_ff  <= out_value_in;
         out_exp_ff    <= out_exp_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit && (cmd.emit_kind == KIND_CLEAR)) begin
            present_ff <= '0;
         end else if (cmd.emit && (cmd.emit_kind == KIND_ADD) && !exp_range) begin
            present_ff[exp_idx] <= 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_value    = out_value_ff;
   assign rsp_result_exponent = out_exp_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_last            = out_last_ff;

endmodule

`default_nettype wire

/* sv/polynomial_term_store_eval_derive.sv */
// add and clear: the S_ADD or S_CLR state loads the result once the output register is free
// evaluate: a multiply and an accumulate state per coefficient from MAX_EXP down to zero, then
//   the output state, which loads the result once the output register is free
// derivative: one entry per cycle from MAX_EXP down, a result per present term of exponent >= 1
// one item at a time; a result waiting on rsp_ready holds the sequencer and so the scan
// reset clears the present bits, the sequencer and rsp_valid; table data is not reset
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_term_store_eval_derive_defines.svh"

// ----------------------------------------------------------------------------
// polynomial_term_store_eval_derive
// polynomial store with term merge, horner evaluation and derivative output
// ----------------------------------------------------------------------------
module polynomial_term_store_eval_derive
   import ptsed_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic        [OP_W-1:0]   req_operation,
   input  wire logic signed [DATA_W-1:0] req_term_coefficient,
   input  wire logic        [EXP_W-1:0]  req_term_exponent,
   input  wire logic signed [DATA_W-1:0] req_point_x,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_result_value,
   output logic        [EXP_W-1:0]       rsp_result_exponent,
   output logic        [ST_W-1:0]        rsp_status,
   output logic                          rsp_last
);

   cmd_type  cmd;
   stat_type st;

   ptsed_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .st            (st),
      .cmd           (cmd)
   );

   ptsed_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_term_coefficient (req_term_coefficient),
      .req_term_exponent    (req_term_exponent),
      .req_point_x          (req_point_x),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_value     (rsp_result_value),
      .rsp_result_exponent  (rsp_result_exponent),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

   // a result is only loaded when the output register is empty or draining
   `PTSED_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, st.out_free)
   // the block is busy the cycle after it takes an item
   `PTSED_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // the scan index never steps below zero
   `PTSED_ASSERT_IMPL(a_idx_no_wrap, clock, reset, cmd.idx_dec, !st.idx_zero)

endmodule

`default_nettype wire

/* tb/ptsed_checker.sv */
// ----------------------------------------------------------------------------
// ptsed_checker
// watches both channels of the polynomial term store, keeps its own copy of
// the coefficient table and scores every result item against the prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsed_checker
   import ptsed_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic        [OP_W-1:0]   req_operation,
   input  wire logic signed [DATA_W-1:0] req_term_coefficient,
   input  wire logic        [EXP_W-1:0]  req_term_exponent,
   input  wire logic signed [DATA_W-1:0] req_point_x,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [DATA_W-1:0] rsp_result_value,
   input  wire logic        [EXP_W-1:0]  rsp_result_exponent,
   input  wire logic        [ST_W-1:0]   rsp_status,
   input  wire logic                     rsp_last,
   output int                            fail_count,
   output int                            owed_count,
   output int                            items_taken,
   output int                            results_seen,
   output int                            sat_seen,
   output int                            empty_seen,
   output int                            range_seen
);

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic        [EXP_W-1:0]  exponent;
      logic        [ST_W-1:0]   status;
      logic                     last;
   } poly_result_type;

   logic signed [DATA_W-1:0] coef_table [TABLE_DEPTH];
   logic                     term_live  [TABLE_DEPTH];
   poly_result_type          owed_results [$];

   int errs    = 0;
   int taken   = 0;
   int seen    = 0;
   int n_sat   = 0;
   int n_empty = 0;
   int n_range = 0;

   function automatic logic signed [DATA_W-1:0] clamp_q(input longint v, inout bit ovf);
      if (v > Q_HI) begin
         ovf = 1'b1;
         return DATA_W'(Q_HI);
      end
      if (v < Q_LO) begin
         ovf = 1'b1;
         return DATA_W'(Q_LO);
      end
      return DATA_W'(v);
   endfunction

   // exact product, round to nearest with ties up, then back to q16.16
   function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b,
                                                      inout bit ovf);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS - 1));
      return clamp_q(p >>> FRAC_BITS, ovf);
   endfunction

   function automatic void wipe_store();
      for (int e = 0; e < TABLE_DEPTH; e++) begin
         coef_table[e] = '0;
         term_live[e]  = 1'b0;
      end
   endfunction

   function automatic void apply_poly_op(input logic        [OP_W-1:0]   op,
                                         input logic signed [DATA_W-1:0] coef,
                                         input logic        [EXP_W-1:0]  ex,
                                         input logic signed [DATA_W-1:0] x);
      bit                       ovf;
      bit                       dsat;
      bit                       any_term;
      int                       n;
      logic signed [DATA_W-1:0] acc;
      logic signed [DATA_W-1:0] c;
      ovf      = 1'b0;
      any_term = 1'b0;
      n        = 0;
      acc      = '0;
      case (op)
         OP_ADD: begin
            if (ex > MAX_EXP) begin
               owed_results.push_back('{'0, '0, ST_RANGE, 1'b1});
            end else begin
               c = clamp_q(longint'(coef_table[ex]) + longint'(coef), ovf);
               coef_table[ex] = c;
               // a term merged down to zero stays present
               term_live[ex] = 1'b1;
               owed_results.push_back('{c, ex, ovf ? ST_SAT : ST_OK, 1'b1});
            end
         end
         OP_EVAL: begin
            for (int e = MAX_EXP; e >= 0; e--) begin
               c = term_live[e] ? coef_table[e] : '0;
               any_term = any_term | term_live[e];
               acc = clamp_q(longint'(q_mul(acc, x, ovf)) + longint'(c), ovf);
            end
            if (!any_term)
               owed_results.push_back('{'0, '0, ST_EMPTY, 1'b1});
            else
               owed_results.push_back('{acc, '0, ovf ? ST_SAT : ST_OK, 1'b1});
         end
         OP_DERIV: begin
            for (int e = MAX_EXP; e >= 1; e--) begin
               if (term_live[e]) begin
                  dsat = 1'b0;
                  c = clamp_q(longint'(coef_table[e]) * e, dsat);
                  owed_results.push_back('{c, EXP_W'(e - 1), dsat ? ST_SAT : ST_OK, 1'b0});
                  n++;
               end
            end
            // only a constant term or nothing: zero polynomial
            if (n == 0)
               owed_results.push_back('{'0, '0, ST_EMPTY, 1'b1});
            else
               owed_results[owed_results.size() - 1].last = 1'b1;
         end
         default: begin
            wipe_store();
            owed_results.push_back('{'0, '0, ST_OK, 1'b1});
         end
      endcase
   endfunction

   always @(posedge clock) begin
      poly_result_type want;
      if (reset) begin
         owed_results.delete();
         wipe_store();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (rsp_status == ST_SAT)   n_sat++;
            if (rsp_status == ST_EMPTY) n_empty++;
            if (rsp_status == ST_RANGE) n_range++;
            if (owed_results.size() == 0) begin
               errs++;
               $error("unexpected result item: value %0d exponent %0d status %0d",
                      rsp_result_value, rsp_result_exponent, rsp_status);
            end else begin
               want = owed_results.pop_front();
               if (rsp_result_value !== want.value) begin
                  errs++;
                  $error("result_value: expected %0d, got %0d", want.value, rsp_result_value);
               end
               if (rsp_result_exponent !== want.exponent) begin
                  errs++;
                  $error("result_exponent: expected %0d, got %0d",
                         want.exponent, rsp_result_exponent);
               end
               if (rsp_status !== want.status) begin
                  errs++;
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
               end
               if (rsp_last !== want.last) begin
                  errs++;
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
               end
            end
         end
         // results of an earlier item are scored before a new item is predicted
         if (req_valid && req_ready) begin
            apply_poly_op(req_operation, req_term_coefficient, req_term_exponent, req_point_x);
            taken++;
         end
      end
      fail_count   <= errs;
      owed_count   <= owed_results.size();
      items_taken  <= taken;
      results_seen <= seen;
      sat_seen     <= n_sat;
      empty_seen   <= n_empty;
      range_seen   <= n_range;
   end

endmodule

/* tb/tb_polynomial_term_store_eval_derive.sv */
// ----------------------------------------------------------------------------
// tb_polynomial_term_store_eval_derive
// drives add, evaluate, derivative and clear items into the polynomial store
// with random gaps and result stalls; scoring is done by ptsed_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polynomial_term_store_eval_derive;
   import ptsed_pkg::*;

   localparam int RANDOM_ITEMS = 480;
   localparam int PHASES       = 4;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 1_500_000;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_TOP = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_BOT = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic        [OP_W-1:0]   req_operation;
   logic signed [DATA_W-1:0] req_term_coefficient;
   logic        [EXP_W-1:0]  req_term_exponent;
   logic signed [DATA_W-1:0] req_point_x;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic        [EXP_W-1:0]  rsp_result_exponent;
   logic        [ST_W-1:0]   rsp_status;
   logic                     rsp_last;

   int fail_count;
   int owed_count;
   int items_taken;
   int results_seen;
   int sat_seen;
   int empty_seen;
   int range_seen;
   int cycle_count = 0;
   bit calm        = 1'b0;

   polynomial_term_store_eval_derive u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_term_coefficient (req_term_coefficient),
      .req_term_exponent    (req_term_exponent),
      .req_point_x          (req_point_x),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_value     (rsp_result_value),
      .rsp_result_exponent  (rsp_result_exponent),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

   ptsed_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_term_coefficient (req_term_coefficient),
      .req_term_exponent    (req_term_exponent),
      .req_point_x          (req_point_x),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_value     (rsp_result_value),
      .rsp_result_exponent  (rsp_result_exponent),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last),
      .fail_count           (fail_count),
      .owed_count           (owed_count),
      .items_taken          (items_taken),
      .results_seen         (results_seen),
      .sat_seen             (sat_seen),
      .empty_seen           (empty_seen),
      .range_seen           (range_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one, none in calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return Q_TOP;
         1:       return Q_BOT;
         2, 3:    return $urandom;
         default: return DATA_W'(int'($urandom_range(0, 'h80000)) - 'h40000);
      endcase
   endfunction

   // small points keep horner out of saturation most of the time
   function automatic logic signed [DATA_W-1:0] pick_point();
      case ($urandom_range(0, 11))
         0:       return Q_TOP;
         1:       return Q_BOT;
         2:       return $urandom;
         3:       return '0;
         4:       return Q_ONE;
         5:       return -Q_ONE;
         6, 7, 8: return DATA_W'(int'($urandom_range(0, 'h23332)) - 'h11999);
         default: return DATA_W'(int'($urandom_range(0, 'h40000)) - 'h20000);
      endcase
   endfunction

   task automatic offer_item(input logic        [OP_W-1:0]   op,
                             input logic signed [DATA_W-1:0] coef,
                             input logic        [EXP_W-1:0]  ex,
                             input logic signed [DATA_W-1:0] x);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_term_coefficient <= coef;
      req_term_exponent    <= ex;
      req_point_x          <= x;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_random();
      int                  r;
      logic [OP_W-1:0]     op;
      logic [EXP_W-1:0]    ex;
      r = $urandom_range(0, 99);
      if (r < 55)      op = OP_ADD;
      else if (r < 75) op = OP_EVAL;
      else if (r < 94) op = OP_DERIV;
      else             op = OP_CLEAR;
      // out of range exponents now and then, the rest land in the table
      if ($urandom_range(0, 99) < 15)
         ex = $urandom_range(0, 63);
      else
         ex = $urandom_range(0, MAX_EXP);
      offer_item(op, pick_coef(), ex, pick_point());
   endtask

   initial begin
      int run_len;
      int stall_len;
      rsp_ready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 20);
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (run_len - 1) @(negedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_operation        = OP_ADD;
      req_term_coefficient = '0;
      req_term_exponent    = '0;
      req_point_x          = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // empty store, constant only, range errors, saturation both ways
      offer_item(OP_EVAL,  '0,          '0,     Q_ONE);
      offer_item(OP_DERIV, '0,          '0,     '0);
      offer_item(OP_ADD,   Q_ONE,       '0,     '0);
      offer_item(OP_DERIV, '0,          '0,     '0);
      offer_item(OP_EVAL,  '0,          '0,     Q_TOP);
      offer_item(OP_ADD,   32'sd5,      6'd16,  '0);
      offer_item(OP_ADD,   Q_TOP,       6'd63,  Q_BOT);
      offer_item(OP_ADD,   Q_TOP,       EXP_W'(MAX_EXP), '0);
      offer_item(OP_ADD,   32'sd1,      EXP_W'(MAX_EXP), '0);
      offer_item(OP_ADD,   Q_BOT,       EXP_W'(MAX_EXP), '0);
      offer_item(OP_ADD,   Q_BOT,       EXP_W'(MAX_EXP), '0);
      // merge to zero keeps the term present
      offer_item(OP_ADD,   5 * Q_ONE,   6'd3,   '0);
      offer_item(OP_ADD,   -5 * Q_ONE,  6'd3,   '0);
      offer_item(OP_ADD,   2 * Q_ONE,   6'd1,   '0);
      offer_item(OP_DERIV, '0,          '0,     '0);
      offer_item(OP_EVAL,  '0,          '0,     Q_BOT);
      offer_item(OP_EVAL,  '0,          '0,     '0);
      offer_item(OP_EVAL,  '0,          '0,     Q_HALF);
      offer_item(OP_CLEAR, Q_TOP,       6'd63,  Q_TOP);
      offer_item(OP_EVAL,  '0,          '0,     Q_ONE);
      // rounding ties on a negative product
      offer_item(OP_ADD,   -32'sd3,     6'd1,   '0);
      offer_item(OP_EVAL,  '0,          '0,     Q_HALF);
      offer_item(OP_EVAL,  '0,          '0,     -Q_HALF);
      offer_item(OP_DERIV, '0,          '0,     '0);
      offer_item(OP_CLEAR, '0,          '0,     '0);

      for (int p = 0; p < PHASES; p++) begin
         calm = (p == 1);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            offer_random();
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("run covered %0d items and %0d result items in %0d cycles",
               items_taken, results_seen, cycle_count);
      $display("  of those %0d saturated, %0d empty, %0d exponent range errors",
               sat_seen, empty_seen, range_seen);
      if (fail_count == 0 && owed_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/ptsed_pkg.sv
sv/ptsed_ctrl.sv
sv/ptsed_dp.sv
sv/polynomial_term_store_eval_derive.sv
tb/ptsed_checker.sv
tb/tb_polynomial_term_store_eval_derive.sv
